// ----- design/drr_pkg.sv -----
// Shared types and constants for the deficit round robin scheduler.
`timescale 1ns / 1ps

package drr_pkg;

    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int DEF_W       = 17;
    localparam int FLOW_IN_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_QUANTUM     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PACKET_BITS = 1'd1;

    localparam logic [CFG_W-1:0] QUANTUM_RESET     = 16'd160;
    localparam logic [CFG_W-1:0] PACKET_BITS_RESET = 16'd80;
    localparam logic [DEF_W-1:0] DEF_MAX           = 17'h1FFFF;

    localparam logic ACT_ARRIVAL    = 1'b0;
    localparam logic ACT_COMPLETION = 1'b1;

    typedef enum logic [1:0] {
        ADDR_ARRIVAL,
        ADDR_GRANTED,
        ADDR_SCAN
    } addr_sel_t;

    typedef struct packed {
        logic      capture;
        addr_sel_t addr_sel;
        logic      rd_en;
        logic      arr_upd;
        logic      cmp_upd;
        logic      scan_init;
        logic      scan_upd;
        logic      out_load;
    } drr_cmd_t;

    typedef struct packed {
        logic action;
        logic flow_ok;
        logic busy;
        logic grant;
        logic scan_last;
        logic out_free;
    } drr_status_t;

endpackage

// ----- design/drr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module drr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/drr_ctrl.sv -----
// Sequencer for the scheduler: decodes a word, walks the flow scan, loads the result.
`timescale 1ns / 1ps

module drr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  drr_pkg::drr_status_t status,
    output drr_pkg::drr_cmd_t    cmd
);

    import drr_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        DISPATCH,
        ARR_RD,
        ARR_WR,
        CMP_RD,
        CMP_WR,
        SCN_RD,
        SCN_WR
    } state_t;

    // FINISH shares no encoding slot; a separate flag marks the result stage
    state_t state_reg, state_next;
    logic   finish_reg, finish_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            finish_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            finish_reg <= finish_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        finish_next = finish_reg;
        cmd         = '0;
        cmd.addr_sel = ADDR_SCAN;
        if (finish_reg)
        begin
            if (status.out_free)
            begin
                cmd.out_load = 1'b1;
                finish_next  = 1'b0;
                state_next   = IDLE;
            end
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = DISPATCH;
                    end
                end
                DISPATCH:
                begin
                    if (status.action == ACT_ARRIVAL)
                    begin
                        if (status.flow_ok)
                            state_next = ARR_RD;
                        else
                            finish_next = 1'b1;
                    end
                    else if (status.busy)
                        state_next = CMP_RD;
                    else
                        finish_next = 1'b1;
                end
                ARR_RD:
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_ARRIVAL;
                    state_next   = ARR_WR;
                end
                ARR_WR:
                begin
                    cmd.arr_upd = 1'b1;
                    if (status.busy)
                        finish_next = 1'b1;
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = SCN_RD;
                    end
                end
                CMP_RD:
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_GRANTED;
                    state_next   = CMP_WR;
                end
                CMP_WR:
                begin
                    cmd.cmp_upd   = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = SCN_RD;
                end
                SCN_RD:
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_SCAN;
                    state_next   = SCN_WR;
                end
                SCN_WR:
                begin
                    cmd.scan_upd = 1'b1;
                    if (status.grant || status.scan_last)
                        finish_next = 1'b1;
                    else
                        state_next = SCN_RD;
                end
                default:
                begin
                    state_next = IDLE;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == IDLE) && !finish_reg;

endmodule

// ----- design/drr_dp.sv -----
// Datapath: per-flow count/deficit RAM, scan pointers, config and result registers.
`timescale 1ns / 1ps

module drr_dp #(
    parameter int FLOWS       = 8,
    parameter int MAX_PACKETS = 1023
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [drr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [drr_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               action,
    input  logic [drr_pkg::FLOW_IN_W-1:0]      flow,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               busy_res,
    output logic [drr_pkg::FLOW_IN_W-1:0]      serving_flow,
    output logic                               dropped,
    input  drr_pkg::drr_cmd_t                  cmd,
    output drr_pkg::drr_status_t               status
);

    import drr_pkg::*;

    localparam int FW  = $clog2(FLOWS);
    localparam int CW  = $clog2(MAX_PACKETS + 1);
    localparam int EW  = CW + DEF_W;
    localparam int XW  = FW + FLOW_IN_W;
    localparam logic [FW-1:0] LAST_FLOW = FW'(FLOWS - 1);
    localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_PACKETS);

    logic [CFG_W-1:0] quantum_reg, packet_bits_reg;
    logic             action_reg;
    logic [FLOW_IN_W-1:0] flow_reg;
    logic [FW-1:0]    rp_reg, granted_reg, idx_reg, visit_reg, wr_addr_reg;
    logic             busy_reg, drop_reg, rd_valid_reg;
    logic [FLOWS-1:0] valid_reg;
    logic             out_valid_reg, busy_res_reg, dropped_reg;
    logic [FLOW_IN_W-1:0] serving_reg;

    logic [XW-1:0]    flow_ext, granted_ext;
    logic             flow_ok;
    logic [FW-1:0]    rd_addr, idx_inc, rp_inc;
    logic [EW-1:0]    rd_data, wr_data;
    logic             wr_en;
    logic [CW-1:0]    cnt;
    logic [DEF_W-1:0] def, def_floor, def_top;
    logic [DEF_W:0]   def_sum;
    logic             cnt_zero, full, eligible, grant;

    assign flow_ext    = XW'(flow_reg);
    assign flow_ok     = flow_ext < XW'(FLOWS);
    assign granted_ext = XW'(granted_reg);
    assign idx_inc     = (idx_reg == LAST_FLOW) ? '0 : idx_reg + 1'b1;
    assign rp_inc      = (rp_reg == LAST_FLOW) ? '0 : rp_reg + 1'b1;

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_ARRIVAL: rd_addr = flow_ext[FW-1:0];
            ADDR_GRANTED: rd_addr = granted_reg;
            ADDR_SCAN:    rd_addr = idx_reg;
            default:      rd_addr = idx_reg;
        endcase
    end

    // entries never written read as empty
    assign cnt = rd_valid_reg ? rd_data[EW-1:DEF_W] : '0;
    assign def = rd_valid_reg ? rd_data[DEF_W-1:0] : '0;

    assign cnt_zero  = (cnt == '0);
    assign full      = (cnt >= CNT_MAX);
    assign def_floor = (def > DEF_W'(packet_bits_reg)) ? def - DEF_W'(packet_bits_reg) : '0;
    assign def_sum   = (DEF_W + 1)'(def) + (DEF_W + 1)'(quantum_reg);
    always_comb
    begin
        if (def < DEF_W'(packet_bits_reg))
            def_top = def_sum[DEF_W] ? DEF_MAX : def_sum[DEF_W-1:0];
        else
            def_top = def;
    end
    assign eligible = (def_top >= DEF_W'(packet_bits_reg));
    assign grant    = !cnt_zero && eligible;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = rd_data;
        if (cmd.arr_upd)
        begin
            wr_en   = 1'b1;
            wr_data = {full ? CNT_MAX : cnt + 1'b1, def};
        end
        else if (cmd.cmp_upd)
        begin
            wr_en   = !cnt_zero;
            wr_data = {cnt - 1'b1, def_floor};
        end
        else if (cmd.scan_upd)
        begin
            wr_en   = 1'b1;
            wr_data = cnt_zero ? {cnt, {DEF_W{1'b0}}} : {cnt, def_top};
        end
    end

    drr_ram #(
        .WIDTH (EW),
        .DEPTH (FLOWS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg     <= QUANTUM_RESET;
            packet_bits_reg <= PACKET_BITS_RESET;
            valid_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            rp_reg          <= '0;
            granted_reg     <= '0;
            busy_reg        <= 1'b0;
            idx_reg         <= '0;
            visit_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUANTUM:     quantum_reg     <= cfg_data;
                    REG_PACKET_BITS: packet_bits_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
                valid_reg[wr_addr_reg] <= 1'b1;
            if (cmd.cmp_upd)
                busy_reg <= 1'b0;
            if (cmd.scan_init)
            begin
                idx_reg   <= rp_inc;
                visit_reg <= '0;
            end
            if (cmd.scan_upd)
            begin
                if (grant)
                begin
                    busy_reg    <= 1'b1;
                    granted_reg <= idx_reg;
                    rp_reg      <= idx_reg;
                end
                else if (visit_reg == LAST_FLOW)
                begin
                    busy_reg    <= 1'b0;
                    granted_reg <= '0;
                    rp_reg      <= idx_reg;
                end
                else
                begin
                    idx_reg   <= idx_inc;
                    visit_reg <= visit_reg + 1'b1;
                end
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            flow_reg   <= flow;
            drop_reg   <= 1'b0;
        end
        else if (cmd.arr_upd)
            drop_reg <= full;
        if (cmd.rd_en)
            wr_addr_reg <= rd_addr;
        if (cmd.out_load)
        begin
            busy_res_reg <= busy_reg;
            serving_reg  <= busy_reg ? granted_ext[FLOW_IN_W-1:0] : '0;
            dropped_reg  <= drop_reg;
        end
    end

    assign status.action    = action_reg;
    assign status.flow_ok   = flow_ok;
    assign status.busy      = busy_reg;
    assign status.grant     = grant;
    assign status.scan_last = (visit_reg == LAST_FLOW);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign busy_res     = busy_res_reg;
    assign serving_flow = serving_reg;
    assign dropped      = dropped_reg;

endmodule

// ----- design/deficit_round_robin_scheduler_core.sv -----
// Deficit round robin scheduler: top level joining sequencer and datapath.
//
// Input channel (in_valid/in_ready, action, flow): one word per packet event,
// an arrival for a flow or a completion of the packet in service.
// Output channel (out_valid/out_ready): one result word per input word with
// busy_res, serving_flow and dropped after that event.
// Config port (cfg_we, cfg_index, cfg_data): index 0 quantum, 1 packet_bits;
// write only while no word is in flight.
// One word is processed at a time: a decode step after capture, a per-flow
// count/deficit RAM access (read, then write), a read and a write for each flow
// a scan visits, up to FLOWS of them, and a step to load the result register.
// An ignored word skips the RAM access and the scan; an arrival while busy
// skips the scan. The next word is accepted in the cycle after the result is
// loaded, so no new word is taken before the last one's result is loaded.
// If the receiver stalls, the following word is taken but holds in its final
// cycle until the output register frees up.
// Reset clears all flow counts and deficits (per-entry valid bits), the
// round pointer and the service state; registers return to 160 and 80.
`timescale 1ns / 1ps

module deficit_round_robin_scheduler_core #(
    parameter int FLOWS       = 8,
    parameter int MAX_PACKETS = 1023
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [drr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [drr_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [drr_pkg::FLOW_IN_W-1:0]   flow,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            busy_res,
    output logic [drr_pkg::FLOW_IN_W-1:0]   serving_flow,
    output logic                            dropped
);

    import drr_pkg::*;

    drr_cmd_t    cmd;
    drr_status_t status;

    drr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    drr_dp #(
        .FLOWS       (FLOWS),
        .MAX_PACKETS (MAX_PACKETS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .flow         (flow),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .busy_res     (busy_res),
        .serving_flow (serving_flow),
        .dropped      (dropped),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
